// File: hw/rtl/bsec_pkg.sv
package bsec_pkg;

    localparam int unsigned MAX_ENTRIES    = 32;
    localparam int unsigned FORMAT_ENTRIES = 126;

    localparam logic [6:0]  COUNT_TOP      = 7'd127;

    localparam logic [7:0]  SPT_RESET      = 8'd22;
    localparam logic [7:0]  TPC_RESET      = 8'd3;
    localparam logic [31:0] VOLUME_RESET   = 32'd53790;

    typedef enum logic [1:0] {
        CFG_SPT    = 2'd0,
        CFG_TPC    = 2'd1,
        CFG_VOLUME = 2'd2
    } cfg_index_t;

    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] linear_sector;
        logic [15:0] entry_cylinder;
        logic [15:0] entry_track_sector;
        logic        out_of_range;
        logic        end_of_list;
        logic        over_limit;
    } item_t;

endpackage

// File: hw/rtl/bsec_front.sv
module bsec_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 cmd,
    input  logic                 first_entry,
    input  logic [31:0]          linear_sector,
    input  logic [15:0]          entry_cylinder,
    input  logic [15:0]          entry_track_sector,
    input  logic [7:0]           spt_nz,
    input  logic [31:0]          volume_size,
    output logic                 push_valid,
    input  logic                 push_ready,
    output bsec_pkg::item_t      push_item
);
    import bsec_pkg::*;

    logic [6:0] entry_count_reg;
    logic [6:0] entry_count_next;
    logic [6:0] idx;
    logic       is_encode;
    logic       eol;
    logic       over;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;

    assign is_encode = (cmd_t'(cmd) == CMD_ENCODE);
    assign idx       = first_entry ? 7'd0 : entry_count_reg;
    assign eol       = !is_encode && entry_cylinder[15];

    always_comb
    begin
        over = (idx >= 7'(MAX_ENTRIES)) || (idx >= 7'(FORMAT_ENTRIES));
        if (is_encode && ({2'b00, idx} >= {spt_nz, 1'b0}))
        begin
            over = 1'b1;
        end
        if (eol)
        begin
            over = 1'b0;
        end
    end

    always_comb
    begin
        if (eol)
        begin
            entry_count_next = idx;
        end
        else if (idx < COUNT_TOP)
        begin
            entry_count_next = idx + 7'd1;
        end
        else
        begin
            entry_count_next = COUNT_TOP;
        end
    end

    always_comb
    begin
        push_item.cmd                = cmd_t'(cmd);
        push_item.linear_sector      = linear_sector;
        push_item.entry_cylinder     = entry_cylinder;
        push_item.entry_track_sector = entry_track_sector;
        push_item.out_of_range       = is_encode && (linear_sector >= volume_size);
        push_item.end_of_list        = eol;
        push_item.over_limit         = over;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (in_valid && push_ready)
        begin
            entry_count_reg <= entry_count_next;
        end
    end

endmodule

// File: hw/rtl/bsec_queue.sv
module bsec_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  bsec_pkg::item_t      push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output bsec_pkg::item_t      pop_item
);
    import bsec_pkg::*;

    item_t      mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// File: hw/rtl/bsec_back.sv
module bsec_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  bsec_pkg::item_t      pop_item,
    input  logic [7:0]           spt_nz,
    input  logic [7:0]           tpc_nz,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [15:0]          cylinder_out,
    output logic [15:0]          track_sector_out,
    output logic [31:0]          sector_number_out,
    output logic [7:0]           track_out,
    output logic [7:0]           sector_out,
    output logic                 out_of_range,
    output logic                 end_of_list,
    output logic                 over_limit
);
    import bsec_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_Q,
        ST_DIV_TS,
        ST_MUL,
        ST_DONE
    } state_t;

    state_t      state_reg;
    item_t       item_reg;
    logic [31:0] dvd_reg;
    logic [15:0] rem_reg;
    logic [15:0] dvsr_reg;
    logic [4:0]  step_reg;
    logic [15:0] q_reg;
    logic [31:0] prod_reg;
    logic        out_valid_reg;
    logic [15:0] cyl_out_reg;
    logic [15:0] ts_out_reg;
    logic [31:0] sn_out_reg;
    logic [7:0]  trk_out_reg;
    logic [7:0]  sec_out_reg;
    logic        oor_out_reg;
    logic        eol_out_reg;
    logic        over_out_reg;

    logic [16:0] div_trial;
    logic        div_ge;
    logic [16:0] div_diff;
    logic [15:0] rem_next;
    logic [31:0] dvd_next;
    logic [24:0] mul_first;
    logic [31:0] mul_second;
    logic        can_load;
    logic [15:0] res_cyl;
    logic [7:0]  res_trk;
    logic [7:0]  res_sec;
    logic [31:0] res_sn;

    assign div_trial = {rem_reg, dvd_reg[31]};
    assign div_ge    = (div_trial >= {1'b0, dvsr_reg});
    assign div_diff  = div_trial - {1'b0, dvsr_reg};
    assign rem_next  = div_ge ? div_diff[15:0] : div_trial[15:0];
    assign dvd_next  = {dvd_reg[30:0], div_ge};

    assign mul_first  = ({9'b0, pop_item.entry_cylinder} * {17'b0, tpc_nz})
                        + {17'b0, pop_item.entry_track_sector[15:8]};
    assign mul_second = 32'(prod_reg * {24'b0, spt_nz})
                        + {24'b0, item_reg.entry_track_sector[7:0]};

    assign pop_ready = (state_reg == ST_IDLE);
    assign can_load  = !out_valid_reg || out_ready;

    always_comb
    begin
        if (item_reg.cmd == CMD_ENCODE)
        begin
            res_cyl = q_reg;
            res_trk = dvd_reg[7:0];
            res_sec = rem_reg[7:0];
            res_sn  = item_reg.linear_sector;
        end
        else
        begin
            res_cyl = item_reg.entry_cylinder;
            res_trk = item_reg.entry_track_sector[15:8];
            res_sec = item_reg.entry_track_sector[7:0];
            res_sn  = item_reg.end_of_list ? 32'd0 : prod_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop_valid)
                    begin
                        item_reg <= pop_item;
                        if (pop_item.cmd == CMD_ENCODE)
                        begin
                            dvd_reg   <= pop_item.linear_sector;
                            rem_reg   <= '0;
                            dvsr_reg  <= {8'b0, spt_nz} * {8'b0, tpc_nz};
                            step_reg  <= 5'd31;
                            state_reg <= ST_DIV_Q;
                        end
                        else if (pop_item.end_of_list)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            prod_reg  <= {7'b0, mul_first};
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_DIV_Q:
                begin
                    if (step_reg == 5'd0)
                    begin
                        q_reg     <= dvd_next[15:0];
                        dvd_reg   <= {rem_next, 16'b0};
                        rem_reg   <= '0;
                        dvsr_reg  <= {8'b0, spt_nz};
                        step_reg  <= 5'd15;
                        state_reg <= ST_DIV_TS;
                    end
                    else
                    begin
                        step_reg <= step_reg - 5'd1;
                        dvd_reg  <= dvd_next;
                        rem_reg  <= rem_next;
                    end
                end
                ST_DIV_TS:
                begin
                    step_reg <= step_reg - 5'd1;
                    dvd_reg  <= dvd_next;
                    rem_reg  <= rem_next;
                    if (step_reg == 5'd0)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= mul_second;
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (can_load)
                    begin
                        out_valid_reg <= 1'b1;
                        cyl_out_reg   <= res_cyl;
                        ts_out_reg    <= (item_reg.cmd == CMD_ENCODE)
                                         ? {res_trk, res_sec}
                                         : item_reg.entry_track_sector;
                        sn_out_reg    <= res_sn;
                        trk_out_reg   <= res_trk;
                        sec_out_reg   <= res_sec;
                        oor_out_reg   <= item_reg.out_of_range;
                        eol_out_reg   <= item_reg.end_of_list;
                        over_out_reg  <= item_reg.over_limit;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid         = out_valid_reg;
    assign cylinder_out      = cyl_out_reg;
    assign track_sector_out  = ts_out_reg;
    assign sector_number_out = sn_out_reg;
    assign track_out         = trk_out_reg;
    assign sector_out        = sec_out_reg;
    assign out_of_range      = oor_out_reg;
    assign end_of_list       = eol_out_reg;
    assign over_limit        = over_out_reg;

`ifndef SYNTHESIS
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_Q && step_reg != 5'd0)
        |=> (state_reg == ST_DIV_Q && step_reg == $past(step_reg) - 5'd1))
        else $error("divider step count broken");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_Q || state_reg == ST_DIV_TS) |-> (rem_reg < dvsr_reg))
        else $error("partial remainder not below divisor");

    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !out_ready) |=> (state_reg == ST_DONE))
        else $error("result dropped while output stalled");
`endif

endmodule

// File: hw/rtl/bad_sector_entry_codec_core.sv
// Encode: a 32-step quotient divide, then a 16-step track/sector divide, on one shared
//   restoring divider; decode: two multiply-add steps; end marker: straight to the result.
// Back end: one transaction in flight, so the next item is popped only after the last result
//   is loaded into the output registers; a 2-entry queue decouples input.
// Reset (rst_n, async, active low): geometry registers 22/3/53790, entry counter 0,
//   queue and output empty.
module bad_sector_entry_codec_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic        first_entry,
    input  logic [31:0] linear_sector,
    input  logic [15:0] entry_cylinder,
    input  logic [15:0] entry_track_sector,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] cylinder_out,
    output logic [15:0] track_sector_out,
    output logic [31:0] sector_number_out,
    output logic [7:0]  track_out,
    output logic [7:0]  sector_out,
    output logic        out_of_range,
    output logic        end_of_list,
    output logic        over_limit
);
    import bsec_pkg::*;

    logic [7:0]  spt_reg;
    logic [7:0]  tpc_reg;
    logic [31:0] volume_reg;
    logic [7:0]  spt_nz;
    logic [7:0]  tpc_nz;

    logic        push_valid;
    logic        push_ready;
    item_t       push_item;
    logic        pop_valid;
    logic        pop_ready;
    item_t       pop_item;

    assign cfg_ready = 1'b1;
    assign spt_nz    = (spt_reg == 8'd0) ? 8'd1 : spt_reg;
    assign tpc_nz    = (tpc_reg == 8'd0) ? 8'd1 : tpc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spt_reg    <= SPT_RESET;
            tpc_reg    <= TPC_RESET;
            volume_reg <= VOLUME_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SPT:    spt_reg    <= cfg_data[7:0];
                CFG_TPC:    tpc_reg    <= cfg_data[7:0];
                CFG_VOLUME: volume_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    bsec_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .cmd                (cmd),
        .first_entry        (first_entry),
        .linear_sector      (linear_sector),
        .entry_cylinder     (entry_cylinder),
        .entry_track_sector (entry_track_sector),
        .spt_nz             (spt_nz),
        .volume_size        (volume_reg),
        .push_valid         (push_valid),
        .push_ready         (push_ready),
        .push_item          (push_item)
    );

    bsec_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    bsec_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .pop_valid         (pop_valid),
        .pop_ready         (pop_ready),
        .pop_item          (pop_item),
        .spt_nz            (spt_nz),
        .tpc_nz            (tpc_nz),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .cylinder_out      (cylinder_out),
        .track_sector_out  (track_sector_out),
        .sector_number_out (sector_number_out),
        .track_out         (track_out),
        .sector_out        (sector_out),
        .out_of_range      (out_of_range),
        .end_of_list       (end_of_list),
        .over_limit        (over_limit)
    );

endmodule
